// File: hdl/ntgm_pkg.sv
// ----------------------------------------------------------------------------
// ntgm_pkg
// Shared types and constants for the nearest timestamp gyro/accel merge.
// ----------------------------------------------------------------------------
package ntgm_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int STAMP_W = 63;
   localparam int WORD_W  = 32;

   localparam logic OP_GYRO  = 1'b0;
   localparam logic OP_ACCEL = 1'b1;

   typedef struct packed {
      logic                     opcode;
      logic [STAMP_W-1:0]       sample_stamp;
      logic signed [WORD_W-1:0] val_x;
      logic signed [WORD_W-1:0] val_y;
      logic signed [WORD_W-1:0] val_z;
   } req_type;

   typedef struct packed {
      logic [STAMP_W-1:0]       merged_stamp;
      logic signed [WORD_W-1:0] acc_x;
      logic signed [WORD_W-1:0] acc_y;
      logic signed [WORD_W-1:0] acc_z;
      logic signed [WORD_W-1:0] gyro_x;
      logic signed [WORD_W-1:0] gyro_y;
      logic signed [WORD_W-1:0] gyro_z;
      logic                     gyro_found;
   } rsp_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] x;
      logic signed [WORD_W-1:0] y;
      logic signed [WORD_W-1:0] z;
   } rates_type;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      rates_type          rates;
   } entry_type;

   typedef struct packed {
      logic             clear;
      logic             load;
      logic [IDX_W-1:0] tag;
   } scan_ctl_type;

   typedef struct packed {
      logic             found;
      logic             busy;
      logic [IDX_W-1:0] idx;
      rates_type        rates;
   } best_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_WRITE,
      ST_RESULT
   } state_type;

endpackage

// File: hdl/ntgm_store.sv
// ----------------------------------------------------------------------------
// ntgm_store
// Gyro sample store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ntgm_store
   import ntgm_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/ntgm_scan.sv
// ----------------------------------------------------------------------------
// ntgm_scan
// Shared distance unit: absolute stamp difference, then best-so-far compare.
// ----------------------------------------------------------------------------
module ntgm_scan
   import ntgm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  scan_ctl_type       ctl,
   input  logic [STAMP_W-1:0] ref_stamp,
   input  entry_type          entry,
   output best_type           best
);

   logic               d_vld_ff, d_vld_in;
   logic [STAMP_W-1:0] d_dist_ff, d_dist_in;
   logic [IDX_W-1:0]   d_tag_ff;
   rates_type          d_rates_ff;

   logic               found_ff, found_in;
   logic [STAMP_W-1:0] best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   rates_type          best_rates_ff, best_rates_in;

   logic [STAMP_W:0]   diff_ab;
   logic [STAMP_W:0]   diff_ba;
   logic               take;

   // both directions in parallel, borrow picks the non-negative one
   always_comb begin
      diff_ab   = {1'b0, ref_stamp} - {1'b0, entry.stamp};
      diff_ba   = {1'b0, entry.stamp} - {1'b0, ref_stamp};
      d_dist_in = diff_ab[STAMP_W] ? diff_ba[STAMP_W-1:0] : diff_ab[STAMP_W-1:0];
      d_vld_in  = ctl.load;
   end

   // strict less-than keeps the earliest entry on ties
   always_comb begin
      take          = d_vld_ff && (!found_ff || (d_dist_ff < best_dist_ff));
      found_in      = found_ff;
      best_dist_in  = best_dist_ff;
      best_idx_in   = best_idx_ff;
      best_rates_in = best_rates_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in      = 1'b1;
         best_dist_in  = d_dist_ff;
         best_idx_in   = d_tag_ff;
         best_rates_in = d_rates_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         d_vld_ff <= d_vld_in;
         found_ff <= found_in;
      end
      d_dist_ff     <= d_dist_in;
      d_tag_ff      <= ctl.tag;
      d_rates_ff    <= entry.rates;
      best_dist_ff  <= best_dist_in;
      best_idx_ff   <= best_idx_in;
      best_rates_ff <= best_rates_in;
   end

   assign best.found = found_ff;
   assign best.busy  = d_vld_ff;
   assign best.idx   = best_idx_ff;
   assign best.rates = best_rates_ff;

endmodule

// File: hdl/nearest_timestamp_gyro_accel_merge.sv
// ----------------------------------------------------------------------------
// nearest_timestamp_gyro_accel_merge
// Pairs each accelerometer sample with the nearest-in-time stored gyro sample.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: opcode 0 stores a gyro sample at the end of a DEPTH-entry
//   store (the oldest entry is dropped when full); opcode 1 is an accel
//   sample that gets merged with the stored gyro sample nearest in time,
//   which is then removed. Gyro requests give no response, accel requests
//   give exactly one on the rsp channel.
//   One request is handled at a time; req_ready is high only while idle.
//   Sequencing, with N stored entries and the match at position p:
//     gyro, store not full:  written straight into the store
//     gyro, store full:      shift out the oldest entry, then write
//     accel, store empty:    straight to the response register
//     accel:                 scan of the N entries through the shared
//                            distance unit, shift the entries after p down
//                            to close the gap, then load the response
//   The store has one read and one write port; each shift reads, then writes.
//   Reset empties the store and drops any pending response. A stalled
//   receiver holds the response register; the block keeps taking requests
//   and only waits when a second response is ready to load.
// ----------------------------------------------------------------------------
module nearest_timestamp_gyro_accel_merge
   import ntgm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   req_type          req_ff, req_in;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] rd_tag_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             accept;
   logic [CNT_W-1:0] idx_next;
   logic             more;
   logic             last_issue;
   logic             rsp_free;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;

   scan_ctl_type     scan_ctl;
   best_type         best;

   ntgm_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ntgm_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .ref_stamp (req_ff.sample_stamp),
      .entry     (rd_data),
      .best      (best)
   );

   always_comb begin
      accept     = req_valid && (state_ff == ST_IDLE);
      idx_next   = CNT_W'(idx_ff) + CNT_W'(1);
      more       = idx_next < fill_ff;
      last_issue = idx_next == fill_ff;
      rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.opcode == OP_GYRO) begin
                  state_in = (fill_ff == CNT_W'(DEPTH)) ? ST_SHIFT_RD : ST_WRITE;
               end else begin
                  state_in = (fill_ff == '0) ? ST_RESULT : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !best.busy) begin
               state_in = ST_SHIFT_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (more) begin
               state_in = ST_SHIFT_WR;
            end else begin
               state_in = (req_ff.opcode == OP_GYRO) ? ST_WRITE : ST_RESULT;
            end
         end
         ST_SHIFT_WR: state_in = ST_SHIFT_RD;
         ST_WRITE:    state_in = ST_IDLE;
         ST_RESULT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      idx_in         = idx_ff;
      fill_in        = fill_ff;
      req_in         = req_ff;
      wr_en          = 1'b0;
      wr_addr        = idx_ff;
      wr_data        = rd_data;
      rd_addr        = idx_ff;
      scan_ctl.clear = 1'b0;
      scan_ctl.load  = rd_vld_ff;
      scan_ctl.tag   = rd_tag_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in         = req_data;
               idx_in         = '0;
               scan_ctl.clear = 1'b1;
            end
         end
         ST_SCAN: begin
            idx_in = idx_next[IDX_W-1:0];
         end
         ST_DRAIN: begin
            idx_in = best.idx;
         end
         ST_SHIFT_RD: begin
            rd_addr = idx_next[IDX_W-1:0];
            if (!more) begin
               fill_in = fill_ff - CNT_W'(1);
            end
         end
         ST_SHIFT_WR: begin
            wr_en  = 1'b1;
            idx_in = idx_next[IDX_W-1:0];
         end
         ST_WRITE: begin
            wr_en               = 1'b1;
            wr_addr             = fill_ff[IDX_W-1:0];
            wr_data.stamp       = req_ff.sample_stamp;
            wr_data.rates.x     = req_ff.val_x;
            wr_data.rates.y     = req_ff.val_y;
            wr_data.rates.z     = req_ff.val_z;
            fill_in             = fill_ff + CNT_W'(1);
         end
         ST_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.merged_stamp = req_ff.sample_stamp;
               rsp_data_in.acc_x        = req_ff.val_x;
               rsp_data_in.acc_y        = req_ff.val_y;
               rsp_data_in.acc_z        = req_ff.val_z;
               rsp_data_in.gyro_found   = best.found;
               rsp_data_in.gyro_x       = best.found ? best.rates.x : '0;
               rsp_data_in.gyro_y       = best.found ? best.rates.y : '0;
               rsp_data_in.gyro_z       = best.found ? best.rates.z : '0;
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rd_vld_ff    <= (state_ff == ST_SCAN);
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      req_ff      <= req_in;
      rd_tag_ff   <= idx_ff;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
      else $error("fill count above store depth");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (fill_ff < CNT_W'(DEPTH)))
      else $error("gyro write into a full store");

   a_shift_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT_RD || state_ff == ST_SHIFT_WR) |-> (fill_ff != '0))
      else $error("shift pass on an empty store");

   a_match_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && !rd_vld_ff && !best.busy) |-> best.found)
      else $error("scan of a non-empty store found no entry");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending response changed under stall");

endmodule
